[hw/rtl/fcf_pkg.sv]
// Package for the framebuffer color filter.
// Holds the register indexes, mode and format codes, and the night shift tables.
// Depends on nothing; every other file imports it.
package fcf_pkg;

  // Pixel and configuration widths
  localparam int PIX_W     = 24;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 4;
  localparam int MODE_W    = 3;
  localparam int FMT_W     = 4;
  localparam int SUM_W     = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 4'd1;

  // Filter modes
  localparam logic [MODE_W-1:0] MODE_OFF      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NS_FIRST = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NS_LAST  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_INVERT   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_GRAY     = 3'd7;

  // Pixel formats
  localparam logic [FMT_W-1:0] FMT_RGB888 = 4'd1;
  localparam logic [FMT_W-1:0] FMT_RGB565 = 4'd2;

  // Divide by three: floor(s * 683 / 2048) is exact for every channel sum here
  localparam logic [SUM_W-1:0] GRAY_RECIP = 10'd683;
  localparam int               GRAY_SHIFT = 11;

  typedef struct packed {
    logic [MODE_W-1:0] filter_mode;
    logic [FMT_W-1:0]  pixel_format;
  } cfg_t;

  // Night shift: blue right shift per level
  function automatic logic [2:0] blue_shift(input logic [MODE_W-1:0] mode);
    logic [2:0] sh;
    case (mode)
      3'd1:    sh = 3'd1;
      3'd2:    sh = 3'd2;
      3'd3:    sh = 3'd3;
      3'd4:    sh = 3'd3;
      3'd5:    sh = 3'd4;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

  // Night shift: green right shift per level
  function automatic logic green_shift(input logic [MODE_W-1:0] mode);
    logic sh;
    case (mode)
      3'd4:    sh = 1'b1;
      3'd5:    sh = 1'b1;
      default: sh = 1'b0;
    endcase
    return sh;
  endfunction

endpackage

[hw/rtl/fcf_in_if.sv]
// Input pixel channel of the framebuffer color filter.
// Uses fcf_pkg for the pixel width.
interface fcf_in_if;
  import fcf_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_end_in;

  modport source (output valid, output pixel_in, output frame_end_in, input ready);
  modport sink   (input valid, input pixel_in, input frame_end_in, output ready);
endinterface

[hw/rtl/fcf_out_if.sv]
// Result pixel channel of the framebuffer color filter.
// Uses fcf_pkg for the pixel width.
interface fcf_out_if;
  import fcf_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_end_out;

  modport source (output valid, output pixel_out, output frame_end_out, input ready);
  modport sink   (input valid, input pixel_out, input frame_end_out, output ready);
endinterface

[hw/rtl/fcf_cfg_if.sv]
// Configuration write channel of the framebuffer color filter.
// Uses fcf_pkg for index and data widths.
interface fcf_cfg_if;
  import fcf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/framebuffer_color_filter.sv]
// Framebuffer color filter: one pixel per cycle while the output is not stalled, two register stages.
// An accepted input beat goes through the input register, then the result register, which drives the result beat.
// Throughput: 1 pixel per cycle unless the output stalls, set by the input register feeding the filter
// and the result register; both stages advance whenever the result is taken.
// Reset (rst_n low, synchronous): pipeline empties, filter_mode and pixel_format go to 0.
module framebuffer_color_filter
  import fcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  fcf_in_if.sink     in_ch,
  fcf_out_if.source  out_ch,
  fcf_cfg_if.sink    cfg_ch
);

  cfg_t             cfg;
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pixel_r;
  logic             s1_fe_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] pixel_out_r;
  logic             fe_out_r;
  logic [PIX_W-1:0] pixel_nxt;
  logic             s2_en;
  logic             in_ready;

  fcf_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  fcf_filter u_filter (
    .cfg       (cfg),
    .pixel_in  (s1_pixel_r),
    .pixel_out (pixel_nxt)
  );

  // Advance when the result slot is free or being drained
  assign s2_en    = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || s2_en;
  assign in_ch.ready = in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_pixel_r <= in_ch.pixel_in;
      s1_fe_r    <= in_ch.frame_end_in;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      pixel_out_r <= pixel_nxt;
      fe_out_r    <= s1_fe_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_out     = pixel_out_r;
  assign out_ch.frame_end_out = fe_out_r;

`ifndef SYNTH
  // Never take a beat into a full input register that cannot drain
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.valid && in_ready && s1_valid_r && !s2_en))
    else $error("input beat overwrote a held pixel");

  // A pixel in the input register moves to the result register when allowed
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_en) |=> out_valid_r)
    else $error("pixel lost between stages");

  // Frame-end flag follows its pixel
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_en) |=> (fe_out_r == $past(s1_fe_r)))
    else $error("frame-end flag corrupted");

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

[hw/rtl/fcf_cfg_regs.sv]
// Configuration registers: filter mode and pixel format.
// Depends on fcf_pkg and fcf_cfg_if.
module fcf_cfg_regs
  import fcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  fcf_cfg_if.sink    cfg_ch,
  output cfg_t       cfg
);

  logic [MODE_W-1:0] filter_mode_r;
  logic [FMT_W-1:0]  pixel_format_r;
  logic              wr_en;

  // Take a write beat every cycle
  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;

  // Decode the index and update the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r  <= MODE_OFF;
      pixel_format_r <= '0;
    end else if (wr_en) begin
      case (cfg_ch.index)
        CFG_FILTER_MODE:  filter_mode_r  <= cfg_ch.data[MODE_W-1:0];
        CFG_PIXEL_FORMAT: pixel_format_r <= cfg_ch.data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.filter_mode  = filter_mode_r;
  assign cfg.pixel_format = pixel_format_r;

endmodule

[hw/rtl/fcf_filter.sv]
// Combinational pixel filter: night shift, invert and grayscale for RGB888/RGB565.
// Depends on fcf_pkg.
module fcf_filter
  import fcf_pkg::*;
(
  input  cfg_t             cfg,
  input  logic [PIX_W-1:0] pixel_in,
  output logic [PIX_W-1:0] pixel_out
);

  logic [7:0]         b8, g8, r8;
  logic [4:0]         b5, r5;
  logic [5:0]         g6;
  logic [SUM_W-1:0]   gray_sum;
  logic [2*SUM_W-1:0] gray_prod;
  logic [7:0]         gray;
  logic [2:0]         bsh;
  logic               gsh;
  logic               is_ns;
  logic [7:0]         b8_f, g8_f, r8_f;
  logic [4:0]         b5_f, r5_f;
  logic [5:0]         g6_f;

  // Split the channels for both layouts
  assign b8 = pixel_in[7:0];
  assign g8 = pixel_in[15:8];
  assign r8 = pixel_in[23:16];
  assign b5 = pixel_in[4:0];
  assign g6 = pixel_in[10:5];
  assign r5 = pixel_in[15:11];

  assign bsh   = blue_shift(cfg.filter_mode);
  assign gsh   = green_shift(cfg.filter_mode);
  assign is_ns = (cfg.filter_mode >= MODE_NS_FIRST) && (cfg.filter_mode <= MODE_NS_LAST);

  // Channel sum; RGB565 takes the top five green bits
  always_comb begin
    if (cfg.pixel_format == FMT_RGB565) begin
      gray_sum = SUM_W'(b5) + SUM_W'(g6[5:1]) + SUM_W'(r5);
    end else begin
      gray_sum = SUM_W'(b8) + SUM_W'(g8) + SUM_W'(r8);
    end
  end

  // Divide by three through the reciprocal
  assign gray_prod = gray_sum * GRAY_RECIP;
  assign gray      = gray_prod[GRAY_SHIFT+7:GRAY_SHIFT];

  // RGB888 channels
  always_comb begin
    b8_f = b8;
    g8_f = g8;
    r8_f = r8;
    if (is_ns) begin
      b8_f = b8 >> bsh;
      g8_f = g8 >> gsh;
    end else if (cfg.filter_mode == MODE_INVERT) begin
      b8_f = ~b8;
      g8_f = ~g8;
      r8_f = ~r8;
    end else if (cfg.filter_mode == MODE_GRAY) begin
      b8_f = gray;
      g8_f = gray;
      r8_f = gray;
    end
  end

  // RGB565 channels
  always_comb begin
    b5_f = b5;
    g6_f = g6;
    r5_f = r5;
    if (is_ns) begin
      b5_f = b5 >> bsh;
      g6_f = g6 >> gsh;
    end else if (cfg.filter_mode == MODE_INVERT) begin
      b5_f = ~b5;
      g6_f = ~g6;
      r5_f = ~r5;
    end else if (cfg.filter_mode == MODE_GRAY) begin
      b5_f = gray[4:0];
      g6_f = {gray[4:0], 1'b0};
      r5_f = gray[4:0];
    end
  end

  // Pick the layout; unknown formats pass through
  always_comb begin
    case (cfg.pixel_format)
      FMT_RGB888: pixel_out = {r8_f, g8_f, b8_f};
      FMT_RGB565: pixel_out = {8'h00, r5_f, g6_f, b5_f};
      default:    pixel_out = pixel_in;
    endcase
  end

endmodule
